@@ sv/bmhq_pkg.sv @@
package bmhq_pkg;

  localparam int HEAP_DEPTH    = 1024;
  localparam int KEY_WIDTH     = 32;
  localparam int PAYLOAD_WIDTH = 32;

  // Slot numbers run 1..HEAP_DEPTH; memory addresses run 0..HEAP_DEPTH-1.
  localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
  localparam int ADDR_W = $clog2(HEAP_DEPTH);

  localparam int S_DATA_W = ((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8;
  localparam int M_DATA_W = ((KEY_WIDTH + PAYLOAD_WIDTH + CNT_W + 7) / 8) * 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LAST,
    S_DOWN,
    S_PLACE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic [KEY_WIDTH-1:0]     key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } ram_rd_t;

  typedef struct packed {
    entry_t           entry;
    logic [CNT_W-1:0] count;
    status_e          status;
  } result_t;

  // Map a heap slot (1-based) onto its memory address.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CNT_W-1:0] slot);
    logic [CNT_W-1:0] tmp;
    tmp = slot - 1'b1;
    return tmp[ADDR_W-1:0];
  endfunction

endpackage

@@ sv/bmhq_ram.sv @@
module bmhq_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 1024,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ sv/bmhq_ctrl.sv @@
module bmhq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmhq_pkg::op_e     in_op_i,
  input  bmhq_pkg::entry_t  in_entry_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bmhq_pkg::result_t res_o,
  output bmhq_pkg::ram_wr_t ram_wr_o,
  output bmhq_pkg::ram_rd_t ram_rd_o,
  input  bmhq_pkg::entry_t  ram_rdata_a_i,
  input  bmhq_pkg::entry_t  ram_rdata_b_i
);

  localparam int CW = bmhq_pkg::CNT_W;

  bmhq_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     pos_q, pos_d;
  bmhq_pkg::entry_t  x_q, x_d;
  bmhq_pkg::entry_t  root_q, root_d;
  bmhq_pkg::entry_t  res_entry_q, res_entry_d;
  bmhq_pkg::status_e res_status_q, res_status_d;
  logic              res_root_q, res_root_d;

  logic              is_full, is_empty;
  logic [CW-1:0]     push_pos;
  logic [CW-1:0]     up_parent;
  logic              up_move;
  logic [CW:0]       n_ext;
  logic [CW:0]       lkid_w;
  logic              has_kids, has_r;
  logic              go_l, go_r, dn_move;
  logic [CW-1:0]     child;
  logic              child_kids;
  bmhq_pkg::entry_t  x_cur;
  bmhq_pkg::entry_t  child_entry;

  assign is_full   = (count_q == CW'(bmhq_pkg::HEAP_DEPTH));
  assign is_empty  = (count_q == '0);
  assign push_pos  = count_q + 1'b1;
  assign up_parent = pos_q >> 1;
  assign up_move   = (x_q.key < ram_rdata_a_i.key);

  assign n_ext    = {1'b0, count_q};
  assign lkid_w   = {pos_q, 1'b0};
  assign has_kids = (lkid_w <= n_ext);
  assign has_r    = ({pos_q, 1'b1} <= n_ext);

  // Left wins only when strictly below both; ties between children go right.
  assign go_l    = (ram_rdata_a_i.key < x_q.key) &&
                   (!has_r || (ram_rdata_a_i.key < ram_rdata_b_i.key));
  assign go_r    = has_r && !go_l && (ram_rdata_b_i.key < x_q.key);
  assign dn_move = go_l || go_r;
  assign child   = go_l ? lkid_w[CW-1:0] : {pos_q[CW-2:0], 1'b1};
  assign child_kids  = ({child, 1'b0} <= n_ext);
  assign child_entry = go_l ? ram_rdata_a_i : ram_rdata_b_i;

  // The last entry arrives from memory while in S_LAST.
  assign x_cur = (state_q == bmhq_pkg::S_LAST) ? ram_rdata_a_i : x_q;

  assign in_ready_o   = (state_q == bmhq_pkg::S_IDLE);
  assign res_valid_o  = (state_q == bmhq_pkg::S_DONE);
  assign res_o.entry  = res_root_q ? root_q : res_entry_q;
  assign res_o.count  = count_q;
  assign res_o.status = res_status_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == bmhq_pkg::OP_PUSH) begin
            if (is_full || is_empty) begin
              state_d = bmhq_pkg::S_DONE;
            end else begin
              state_d = bmhq_pkg::S_UP;
            end
          end else begin
            if (is_empty || (count_q == CW'(1))) begin
              state_d = bmhq_pkg::S_DONE;
            end else begin
              state_d = bmhq_pkg::S_LAST;
            end
          end
        end
      end
      bmhq_pkg::S_UP: begin
        if (up_move) begin
          state_d = (up_parent == CW'(1)) ? bmhq_pkg::S_PLACE : bmhq_pkg::S_UP;
        end else begin
          state_d = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_LAST: begin
        state_d = has_kids ? bmhq_pkg::S_DOWN : bmhq_pkg::S_DONE;
      end
      bmhq_pkg::S_DOWN: begin
        if (dn_move) begin
          state_d = child_kids ? bmhq_pkg::S_DOWN : bmhq_pkg::S_PLACE;
        end else begin
          state_d = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_PLACE: begin
        state_d = bmhq_pkg::S_DONE;
      end
      bmhq_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = bmhq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    count_d       = count_q;
    pos_d         = pos_q;
    x_d           = x_q;
    root_d        = root_q;
    res_entry_d   = res_entry_q;
    res_status_d  = res_status_q;
    res_root_d    = res_root_q;
    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = bmhq_pkg::slot_addr(pos_q);
    ram_wr_o.data = x_cur;
    ram_rd_o.addr_a = bmhq_pkg::slot_addr(lkid_w[CW-1:0]);
    ram_rd_o.addr_b = bmhq_pkg::slot_addr({pos_q[CW-2:0], 1'b1});
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == bmhq_pkg::OP_PUSH) begin
            res_root_d   = 1'b1;
            res_status_d = is_full ? bmhq_pkg::ST_FULL : bmhq_pkg::ST_OK;
            if (!is_full) begin
              count_d = push_pos;
              x_d     = in_entry_i;
              pos_d   = push_pos;
              if (is_empty) begin
                ram_wr_o.en   = 1'b1;
                ram_wr_o.addr = bmhq_pkg::slot_addr(CW'(1));
                ram_wr_o.data = in_entry_i;
                root_d        = in_entry_i;
              end else begin
                ram_rd_o.addr_a = bmhq_pkg::slot_addr(push_pos >> 1);
              end
            end
          end else begin
            res_root_d = 1'b0;
            if (is_empty) begin
              res_entry_d  = '0;
              res_status_d = bmhq_pkg::ST_EMPTY;
            end else begin
              res_entry_d     = root_q;
              res_status_d    = bmhq_pkg::ST_OK;
              count_d         = count_q - 1'b1;
              pos_d           = CW'(1);
              ram_rd_o.addr_a = bmhq_pkg::slot_addr(count_q);
            end
          end
        end
      end
      bmhq_pkg::S_UP: begin
        ram_wr_o.en = 1'b1;
        if (up_move) begin
          // Pull the parent down into the hole and climb.
          ram_wr_o.data   = ram_rdata_a_i;
          pos_d           = up_parent;
          ram_rd_o.addr_a = bmhq_pkg::slot_addr(up_parent >> 1);
        end
      end
      bmhq_pkg::S_LAST: begin
        x_d = ram_rdata_a_i;
        if (!has_kids) begin
          ram_wr_o.en = 1'b1;
          root_d      = ram_rdata_a_i;
        end
      end
      bmhq_pkg::S_DOWN: begin
        ram_wr_o.en = 1'b1;
        if (dn_move) begin
          // Lift the chosen child into the hole and descend.
          ram_wr_o.data   = child_entry;
          pos_d           = child;
          ram_rd_o.addr_a = bmhq_pkg::slot_addr({child[CW-2:0], 1'b0});
          ram_rd_o.addr_b = bmhq_pkg::slot_addr({child[CW-2:0], 1'b1});
          if (pos_q == CW'(1)) begin
            root_d = child_entry;
          end
        end else if (pos_q == CW'(1)) begin
          root_d = x_q;
        end
      end
      bmhq_pkg::S_PLACE: begin
        ram_wr_o.en = 1'b1;
        if (pos_q == CW'(1)) begin
          root_d = x_q;
        end
      end
      bmhq_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    x_q          <= x_d;
    root_q       <= root_d;
    res_entry_q  <= res_entry_d;
    res_status_q <= res_status_d;
    res_root_q   <= res_root_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(bmhq_pkg::HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_no_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmhq_pkg::S_DONE) |-> !ram_wr_o.en)
    else $error("memory write while result pending");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmhq_pkg::S_UP) |-> (pos_q > CW'(1)))
    else $error("sift-up hole at root");

  a_down_has_kid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmhq_pkg::S_DOWN) |-> (lkid_w <= n_ext))
    else $error("sift-down read beyond last entry");

endmodule

@@ sv/binary_min_heap_queue_core.sv @@
// Channel  Dir  Payload (lowest bit first)                          Transaction
// s_*      in   tuser: op; tdata: key_in, payload_in               tvalid & tready
// m_*      out  tuser: status; tdata: key_out, payload_out, count  tvalid & tready
//
// One transaction in gives one transaction out, one item at a time: the core takes no new
// item until the result of the last one has been handed to the output register. A push
// climbs the tree and a pop descends it, with one memory read round trip per tree level.
// Reset clears the state, the entry count and the output valid flag; the heap memory
// needs no clearing pass. A result waits in the output register while the next item is
// taken; the core stalls only at its own finish while that register is still occupied.
module binary_min_heap_queue_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // [31:0] key_in, [63:32] payload_in
  input  logic [bmhq_pkg::S_DATA_W-1:0] s_tdata_i,
  // [0] op
  input  logic [0:0]                    s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [31:0] key_out, [63:32] payload_out, [74:64] item_count, rest zero
  output logic [bmhq_pkg::M_DATA_W-1:0] m_tdata_o,
  // [1:0] status
  output logic [1:0]                    m_tuser_o
);

  bmhq_pkg::entry_t  in_entry;
  bmhq_pkg::result_t res;
  logic              res_valid, res_ready;
  bmhq_pkg::ram_wr_t ram_wr;
  bmhq_pkg::ram_rd_t ram_rd;
  bmhq_pkg::entry_t  rdata_a, rdata_b;

  logic                          out_valid_q;
  logic [bmhq_pkg::M_DATA_W-1:0] out_data_q;
  logic [1:0]                    out_user_q;

  // Unpack the incoming transaction.
  assign in_entry.key     = s_tdata_i[bmhq_pkg::KEY_WIDTH-1:0];
  assign in_entry.payload = s_tdata_i[bmhq_pkg::KEY_WIDTH +: bmhq_pkg::PAYLOAD_WIDTH];

  bmhq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid_i),
    .in_ready_o    (s_tready_o),
    .in_op_i       (bmhq_pkg::op_e'(s_tuser_i[0])),
    .in_entry_i    (in_entry),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_wr_o      (ram_wr),
    .ram_rd_o      (ram_rd),
    .ram_rdata_a_i (rdata_a),
    .ram_rdata_b_i (rdata_b)
  );

  bmhq_ram #(
    .DATA_W (bmhq_pkg::ENTRY_W),
    .DEPTH  (bmhq_pkg::HEAP_DEPTH),
    .AW     (bmhq_pkg::ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_wr.en),
    .waddr_i   (ram_wr.addr),
    .wdata_i   (ram_wr.data),
    .raddr_a_i (ram_rd.addr_a),
    .raddr_b_i (ram_rd.addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Load the output register whenever it is empty or being drained.
  assign res_ready = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the payload until the downstream side takes it.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= bmhq_pkg::M_DATA_W'({res.count, res.entry.payload, res.entry.key});
      out_user_q <= res.status;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

endmodule
